FILE: rtl/stereo_boxcar_average_assert.svh
// assertion helpers for the stereo boxcar average block
`ifndef STEREO_BOXCAR_AVERAGE_ASSERT_SVH
`define STEREO_BOXCAR_AVERAGE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned WIN_W    = 6;
  localparam int unsigned RCP_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RCP    = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd1;
  localparam logic [RCP_W-1:0] RCP_RESET    = 17'h10000;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic clear;      // start a new sum
    logic acc_en;     // add the history word read last cycle
    logic mul_right;  // multiplier takes the right sum
    logic mul_en;     // register a product
    logic sat_left;   // product in the register belongs to the left channel
    logic sat_right;  // product in the register belongs to the right channel
  } sba_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sba_hist_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module sba_hist_mem
  import sba_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [2*SAMPLE_W-1:0]   wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [2*SAMPLE_W-1:0]   rdata_o
);

  logic [2*SAMPLE_W-1:0] mem_q [DEPTH];
  logic [2*SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/sba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sba_datapath
  import sba_pkg::*;
#(
  parameter int unsigned SW = 30
) (
  input  logic                       clk_i,
  input  sba_ctl_t                   ctl_i,
  input  logic [2*SAMPLE_W-1:0]      rdata_i,
  input  logic [RCP_W-1:0]           rcp_i,
  output logic signed [SAMPLE_W-1:0] res_left_o,
  output logic signed [SAMPLE_W-1:0] res_right_o
);

  localparam int unsigned PW = SW + RCP_W + 1;
  localparam int unsigned QW = PW - 16;

  logic signed [SW-1:0]       acc_l_q, acc_r_q;
  logic signed [SW-1:0]       mul_a;
  logic signed [RCP_W:0]      mul_b;
  logic signed [PW-1:0]       prod_q;
  logic signed [QW-1:0]       quo;
  logic [QW-1-(SAMPLE_W-1):0] quo_hi;
  logic signed [SAMPLE_W-1:0] sat;
  logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;

  // two accumulator lanes, one per channel
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_l_q <= acc_l_q + SW'($signed(rdata_i[SAMPLE_W-1:0]));
      acc_r_q <= acc_r_q + SW'($signed(rdata_i[2*SAMPLE_W-1:SAMPLE_W]));
    end
  end

  // one multiplier shared by both channels
  assign mul_a = ctl_i.mul_right ? acc_r_q : acc_l_q;
  assign mul_b = $signed({1'b0, rcp_i});

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // arithmetic shift is floor rounding, then clamp to 24 bits
  assign quo    = prod_q[PW-1:16];
  assign quo_hi = quo[QW-1:SAMPLE_W-1];

  always_comb begin
    if (quo_hi == '0 || quo_hi == '1) begin
      sat = quo[SAMPLE_W-1:0];
    end else if (quo[QW-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sat_left) begin
      res_l_q <= sat;
    end
    if (ctl_i.sat_right) begin
      res_r_q <= sat;
    end
  end

  assign res_left_o  = res_l_q;
  assign res_right_o = res_r_q;

endmodule

`default_nettype wire

FILE: rtl/stereo_boxcar_average.sv
// sequence: accept, history write, sum of the window (clamped to HISTORY_DEPTH - 2),
//   scale and saturate per channel; bypass (window of 0 or 1) passes the sample
// flow: one item at a time, the next taken once its result is registered, which
//   waits on m_axis_tready; the history walk reads one stereo word per cycle
//   from the single read port of the history memory
// reset: async active low; history reads as zero until written (fill count),
//   window 1 (bypass), weight 1.0, write position zero; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module stereo_boxcar_average
  import sba_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [RCP_W-1:0]       cfg_data_i,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*SAMPLE_W-1:0]  s_axis_tdata,  // sample_left, sample_right
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*SAMPLE_W-1:0]  m_axis_tdata   // average_left, average_right
);

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW   = AW + 1;
  localparam int unsigned CNTW = (FW > WIN_W) ? FW : WIN_W;
  localparam int unsigned SW   = SAMPLE_W + AW;

  localparam logic [CNTW-1:0] WIN_MAX  = CNTW'(HISTORY_DEPTH - 2);
  localparam logic [AW-1:0]   LAST_POS = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0]   FILL_MAX = FW'(HISTORY_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL_L = 3'd4;
  localparam logic [2:0] S_MUL_R = 3'd5;
  localparam logic [2:0] S_SAT_R = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [WIN_W-1:0]      window_q;
  logic [RCP_W-1:0]      rcp_q;
  logic [CNTW-1:0]       win_lim;
  logic [CNTW-1:0]       win_q;
  logic                  bypass_q;
  logic [2*SAMPLE_W-1:0] samp_q;
  logic [AW-1:0]         wp_q;
  logic [FW-1:0]         fill_q;
  logic [AW-1:0]         rd_ptr_q;
  logic [CNTW-1:0]       j_q;
  logic                  issue_q, live_q;
  logic                  out_valid_q;
  logic [2*SAMPLE_W-1:0] out_data_q;
  logic                  in_fire, out_free;
  logic [2*SAMPLE_W-1:0] rdata;
  logic signed [SAMPLE_W-1:0] res_l, res_r;
  sba_ctl_t              ctl;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // window clamped to the history depth
  assign win_lim = (CNTW'(window_q) > WIN_MAX) ? WIN_MAX : CNTW'(window_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      rcp_q    <= RCP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
        REG_RCP:    rcp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (win_lim <= CNTW'(1)) ? S_DONE : S_WRITE;
        end
      end
      S_WRITE: state_d = S_SUM;
      S_SUM: begin
        if (j_q == win_q - CNTW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_MUL_L;
      S_MUL_L: state_d = S_MUL_R;
      S_MUL_R: state_d = S_SAT_R;
      S_SAT_R: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      j_q         <= '0;
      issue_q     <= 1'b0;
      live_q      <= 1'b0;
      win_q       <= '0;
      bypass_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= (state_q == S_SUM);
      if (in_fire) begin
        win_q    <= win_lim;
        bypass_q <= (win_lim <= CNTW'(1));
      end
      if (state_q == S_WRITE) begin
        // newest entry goes in first, the walk starts on it
        rd_ptr_q <= wp_q;
        j_q      <= '0;
        wp_q     <= (wp_q == LAST_POS) ? '0 : wp_q + AW'(1);
        if (fill_q != FILL_MAX) begin
          fill_q <= fill_q + FW'(1);
        end
      end
      if (state_q == S_SUM) begin
        // entries never written since reset count as zero
        live_q   <= (FW'(rd_ptr_q) < fill_q);
        rd_ptr_q <= (rd_ptr_q == '0) ? LAST_POS : rd_ptr_q - AW'(1);
        j_q      <= j_q + CNTW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      samp_q <= s_axis_tdata;
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q <= bypass_q ? samp_q : {res_r, res_l};
    end
  end

  assign ctl.clear     = (state_q == S_WRITE);
  assign ctl.acc_en    = issue_q && live_q;
  assign ctl.mul_right = (state_q == S_MUL_R);
  assign ctl.mul_en    = (state_q == S_MUL_L) || (state_q == S_MUL_R);
  assign ctl.sat_left  = (state_q == S_MUL_R);
  assign ctl.sat_right = (state_q == S_SAT_R);

  sba_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (wp_q),
    .wdata_i (samp_q),
    .re_i    (state_q == S_SUM),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  sba_datapath #(
    .SW (SW)
  ) u_dp (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .rdata_i     (rdata),
    .rcp_i       (rcp_q),
    .res_left_o  (res_l),
    .res_right_o (res_r)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`include "stereo_boxcar_average_assert.svh"

  // fill count saturates at the depth
  `SBA_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_q <= FILL_MAX, "fill count above depth")
  // one item in flight at a time
  `SBA_ASSERT_NEXT(a_one_item, in_fire, !s_axis_tready, "accepted item while busy")
  // the walk never issues more reads than the window
  `SBA_ASSERT_IMPLIES(a_walk_len, state_q == S_SUM, j_q < win_q, "history walk overran")
  // bypass skips the history entirely
  `SBA_ASSERT_NEXT(a_bypass, in_fire && win_lim <= CNTW'(1), state_q == S_DONE,
                   "bypass item touched history")

endmodule

`default_nettype wire
